// ----- hw/rtl/fpba_pkg.sv -----
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types, codes and defaults of the fit-policy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

    localparam int NBLOCKS_DEF   = 16;
    localparam int SIZE_BITS_DEF = 16;

    localparam int MODE_W   = 2;
    localparam int COUNT_W  = 5;
    localparam int IDX_W    = 4;
    localparam int AMOUNT_W = 16;
    localparam int CFG_W    = 5;

    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    localparam logic CFG_FIT_MODE    = 1'b0;
    localparam logic CFG_BLOCK_COUNT = 1'b1;

    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 5'd16;

    typedef struct packed {
        logic [MODE_W-1:0]  fit_mode;
        logic [COUNT_W-1:0] block_count;
    } t_cfg;

    typedef struct packed {
        logic                is_req;
        logic                in_range;
        logic [IDX_W-1:0]    idx;
        logic [AMOUNT_W-1:0] amount;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_bk_state;

endpackage

`default_nettype wire

// ----- hw/rtl/fpba_front.sv -----
// ----------------------------------------------------------------------------
// fpba_front
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_front
    import fpba_pkg::*;
#(
    parameter int NBLOCKS = NBLOCKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,
    output logic             o_q_valid,
    output t_cmd             o_q_cmd,
    input  wire logic        i_q_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;

    always_comb begin
        w_cmd.is_req   = s_axis_tuser;
        w_cmd.idx      = s_axis_tdata[IDX_W-1:0];
        w_cmd.amount   = s_axis_tdata[IDX_W +: AMOUNT_W];
        w_cmd.in_range = (32'(s_axis_tdata[IDX_W-1:0]) < 32'(NBLOCKS));
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_q_valid     = (r_cnt != 2'd0);
    assign o_q_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fpba_back.sv -----
// ----------------------------------------------------------------------------
// fpba_back
// Carries out loads and requests on the free-size table and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_back
    import fpba_pkg::*;
#(
    parameter int NBLOCKS   = NBLOCKS_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_q_valid,
    input  wire t_cmd        i_q_cmd,
    output logic             o_q_pop,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,
    output logic             m_axis_tuser
);

    localparam int IW   = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;
    localparam int CW0  = $clog2(NBLOCKS + 1);
    localparam int CW   = (CW0 > COUNT_W) ? CW0 : COUNT_W;
    localparam int SW   = SIZE_BITS;
    localparam int AXW  = (SW > AMOUNT_W) ? SW : AMOUNT_W;
    localparam int PXW  = (IW > IDX_W) ? IW : IDX_W;

    logic [SW-1:0]       r_mem [NBLOCKS];
    logic [NBLOCKS-1:0]  r_vld;
    logic [SW-1:0]       r_rd_data;
    logic                r_rd_vld;

    t_bk_state           r_state;
    t_bk_state           n_state;
    logic [MODE_W-1:0]   r_mode;
    logic [SW-1:0]       r_amt;
    logic [CW-1:0]       r_n;
    logic [CW-1:0]       r_ra;
    logic                r_pv;
    logic [IW-1:0]       r_pidx;
    logic                r_found;
    logic [SW-1:0]       r_best;
    logic [IW-1:0]       r_pick;

    logic                r_out_valid;
    logic                r_out_granted;
    logic [IDX_W-1:0]    r_out_blk;
    logic [AMOUNT_W-1:0] r_out_rem;

    logic [CW-1:0]       w_count;
    logic [CW-1:0]       w_n_use;
    logic [AXW-1:0]      w_amt_x;
    logic [SW-1:0]       w_amt_in;
    logic [IW-1:0]       w_ld_addr;
    logic [PXW-1:0]      w_idx_x;
    logic [IW-1:0]       w_rd_addr;
    logic [SW-1:0]       w_rd;
    logic                w_fits;
    logic                w_take;
    logic                w_grant;
    logic [SW-1:0]       w_new;
    logic [AXW-1:0]      w_new_x;
    logic [AXW-1:0]      w_ld_x;
    logic [PXW-1:0]      w_pick_x;
    logic                w_out_free;
    logic                w_start;

    logic                w_pop;
    logic                w_mem_we;
    logic [IW-1:0]       w_wa;
    logic [SW-1:0]       w_wd;
    logic                w_out_ld;
    logic                w_out_granted;
    logic [IDX_W-1:0]    w_out_blk;
    logic [AMOUNT_W-1:0] w_out_rem;

    assign w_count   = CW'(i_cfg.block_count);
    assign w_n_use   = (w_count > CW'(NBLOCKS)) ? CW'(NBLOCKS) : w_count;
    assign w_amt_x   = AXW'(i_q_cmd.amount);
    assign w_amt_in  = w_amt_x[SW-1:0];
    assign w_idx_x   = PXW'(i_q_cmd.idx);
    assign w_ld_addr = w_idx_x[IW-1:0];
    assign w_ld_x    = AXW'(w_amt_in);
    assign w_rd_addr = r_ra[IW-1:0];
    assign w_rd      = r_rd_vld ? r_rd_data : '0;
    assign w_fits    = (w_rd >= r_amt);
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_grant   = r_found && ((r_mode != FIT_WORST) || (r_best >= r_amt));
    assign w_new     = r_best - r_amt;
    assign w_new_x   = AXW'(w_new);
    assign w_pick_x  = PXW'(r_pick);

    always_comb begin
        case (r_mode)
            FIT_BEST:  w_take = w_fits && (!r_found || (w_rd < r_best));
            FIT_WORST: w_take = !r_found || (w_rd > r_best);
            default:   w_take = !r_found && w_fits;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && i_q_cmd.is_req && (w_n_use != '0)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_ra == r_n - CW'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_pop         = 1'b0;
        w_start       = 1'b0;
        w_mem_we      = 1'b0;
        w_wa          = w_ld_addr;
        w_wd          = w_amt_in;
        w_out_ld      = 1'b0;
        w_out_granted = 1'b0;
        w_out_blk     = '0;
        w_out_rem     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && i_q_cmd.is_req && (w_n_use != '0)) begin
                    w_pop   = 1'b1;
                    w_start = 1'b1;
                end else if (i_q_valid && w_out_free) begin
                    w_pop    = 1'b1;
                    w_out_ld = 1'b1;
                    if (!i_q_cmd.is_req) begin
                        w_mem_we  = i_q_cmd.in_range;
                        w_out_blk = i_q_cmd.idx;
                        w_out_rem = w_ld_x[AMOUNT_W-1:0];
                    end
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    w_out_ld = 1'b1;
                    if (w_grant) begin
                        w_mem_we      = 1'b1;
                        w_wa          = r_pick;
                        w_wd          = w_new;
                        w_out_granted = 1'b1;
                        w_out_blk     = w_pick_x[IDX_W-1:0];
                        w_out_rem     = w_new_x[AMOUNT_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_q_pop = w_pop;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (w_mem_we) begin
                r_vld[w_wa] <= 1'b1;
            end
            r_rd_vld <= r_vld[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pv        <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == ST_SCAN);
            if (w_start) begin
                r_found <= 1'b0;
            end else if (r_pv && w_take) begin
                r_found <= 1'b1;
            end
            if (w_out_ld) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_mode <= i_cfg.fit_mode;
            r_amt  <= w_amt_in;
            r_n    <= w_n_use;
            r_ra   <= '0;
        end else if (r_state == ST_SCAN) begin
            r_ra <= r_ra + CW'(1);
        end
        r_pidx <= w_rd_addr;
        if (r_pv && w_take) begin
            r_best <= w_rd;
            r_pick <= r_pidx;
        end
        if (w_out_ld) begin
            r_out_granted <= w_out_granted;
            r_out_blk     <= w_out_blk;
            r_out_rem     <= w_out_rem;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_granted;
    assign m_axis_tdata  = {4'd0, r_out_rem, r_out_blk};

`ifndef SYNTHESIS
    a_pop_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("pop from empty queue");

    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == ST_IDLE))
        else $error("pop while busy");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_ra < r_n))
        else $error("scan address past block count");

    a_eval_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (CW'(r_pidx) < r_n))
        else $error("evaluated entry past block count");

    a_grant_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_ld && w_out_granted) |-> (r_found && (r_state == ST_DONE)))
        else $error("grant without a chosen block");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/fit_policy_block_allocator.sv -----
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Free-size table with first, best and worst fit placement of requests.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel: tuser is the kind (0 load, 1 request),
// tdata carries load_index and amount. Each item gives one result on the
// m_axis channel: tuser is granted, tdata carries block_number and remaining.
// A load writes one entry; its result passes through the queue and the result
// register, and loads can be taken every cycle while no request is being
// scanned and the result side keeps up. A request reads the table one entry
// per cycle through the single read port of the table memory, over the first
// block_count entries (at most NBLOCKS), so it occupies the back end through
// the scan, drain and done states; its result is loaded at the end of them.
// With block_count zero a request is denied without a scan, like a load.
// A two-entry queue sits between input and back end, so up to two items are
// taken while a request is being scanned.
// The result register holds its item while m_axis_tready is low; the back end
// then holds, the queue fills and s_axis_tready drops.
// Reset clears all entries to zero (per-entry valid bits), fit_mode to first
// fit and block_count to 16. Write configuration through i_cfg_* only while
// no item is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module fit_policy_block_allocator
    import fpba_pkg::*;
#(
    parameter int NBLOCKS   = NBLOCKS_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic             i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [23:0]      s_axis_tdata,   // load_index[3:0], amount[19:4]
    input  wire logic             s_axis_tuser,   // kind
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // block_number[3:0], remaining[19:4]
    output logic                  m_axis_tuser    // granted
);

    t_cfg r_cfg;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fit_mode    <= FIT_FIRST;
            r_cfg.block_count <= BLOCK_COUNT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FIT_MODE:    r_cfg.fit_mode    <= i_cfg_data[MODE_W-1:0];
                CFG_BLOCK_COUNT: r_cfg.block_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    fpba_front #(
        .NBLOCKS (NBLOCKS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_q_valid     (w_q_valid),
        .o_q_cmd       (w_q_cmd),
        .i_q_pop       (w_q_pop)
    );

    fpba_back #(
        .NBLOCKS   (NBLOCKS),
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_cmd       (w_q_cmd),
        .o_q_pop       (w_q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- bench/tb_fit_policy_block_allocator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fit_policy_block_allocator
// Self-checking bench for the free-size table with first, best and worst fit.
// ----------------------------------------------------------------------------
// A directed table walks the corner cases: an empty table after reset,
// requests that are denied, the unused policy code, a block count of zero and
// counts above the table size, and loads above the block count. Random phases
// follow, each under its own policy and block count. Every accepted item runs
// through a local model of the table, and each result is compared against the
// oldest pending prediction. Both stream sides idle at random. One phase runs
// without gaps. In another phase the result side holds off long enough for
// the input side to stall.
// ----------------------------------------------------------------------------

module tb_fit_policy_block_allocator;
    import fpba_pkg::*;

    localparam int  TABLE_DEPTH  = 16;
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_REQ    = 1'b1;
    localparam logic [MODE_W-1:0] FIT_UNUSED = 2'd3;
    localparam int  PHASES       = 14;
    localparam int  PHASE_ITEMS  = 115;
    localparam int  HOLD_CYCLES  = 400;

    typedef struct packed {
        logic                granted;
        logic [IDX_W-1:0]    block;
        logic [AMOUNT_W-1:0] remaining;
    } t_alloc_result;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [COUNT_W-1:0]  count;
        logic                kind;
        logic [IDX_W-1:0]    idx;
        logic [AMOUNT_W-1:0] amount;
        logic                typed;
        t_alloc_result       res;
    } t_step_row;

    localparam t_alloc_result DENIED = '0;
    localparam t_alloc_result UNTYPED = '0;

    localparam t_step_row PLAN [0:21] = '{
        '{FIT_FIRST, 5'd16, KIND_REQ,  4'd0,  16'd0,     1'b1, '{1'b1, 4'd0, 16'd0}},
        '{FIT_FIRST, 5'd16, KIND_REQ,  4'd15, 16'd1,     1'b1, DENIED},
        '{FIT_FIRST, 5'd16, KIND_LOAD, 4'd15, 16'hFFFF,  1'b1, '{1'b0, 4'd15, 16'hFFFF}},
        '{FIT_FIRST, 5'd16, KIND_LOAD, 4'd0,  16'd100,   1'b1, '{1'b0, 4'd0, 16'd100}},
        '{FIT_FIRST, 5'd16, KIND_LOAD, 4'd1,  16'd50,    1'b1, '{1'b0, 4'd1, 16'd50}},
        '{FIT_FIRST, 5'd16, KIND_LOAD, 4'd2,  16'd200,   1'b1, '{1'b0, 4'd2, 16'd200}},
        '{FIT_FIRST, 5'd16, KIND_LOAD, 4'd3,  16'd50,    1'b1, '{1'b0, 4'd3, 16'd50}},
        '{FIT_FIRST, 5'd16, KIND_REQ,  4'd7,  16'd60,    1'b0, UNTYPED},
        '{FIT_BEST,  5'd16, KIND_REQ,  4'd0,  16'd45,    1'b0, UNTYPED},
        '{FIT_WORST, 5'd16, KIND_REQ,  4'd0,  16'd1000,  1'b0, UNTYPED},
        '{FIT_WORST, 5'd16, KIND_REQ,  4'd0,  16'hFFFF,  1'b1, DENIED},
        '{FIT_UNUSED, 5'd16, KIND_REQ, 4'd0,  16'd10,    1'b0, UNTYPED},
        '{FIT_FIRST, 5'd0,  KIND_REQ,  4'd0,  16'd0,     1'b1, DENIED},
        '{FIT_WORST, 5'd31, KIND_REQ,  4'd0,  16'd1,     1'b0, UNTYPED},
        '{FIT_BEST,  5'd1,  KIND_REQ,  4'd0,  16'd31,    1'b0, UNTYPED},
        '{FIT_BEST,  5'd1,  KIND_REQ,  4'd0,  16'd30,    1'b0, UNTYPED},
        '{FIT_FIRST, 5'd4,  KIND_LOAD, 4'd10, 16'd500,   1'b1, '{1'b0, 4'd10, 16'd500}},
        '{FIT_FIRST, 5'd4,  KIND_REQ,  4'd0,  16'd400,   1'b0, UNTYPED},
        '{FIT_FIRST, 5'd16, KIND_REQ,  4'd0,  16'd400,   1'b0, UNTYPED},
        '{FIT_FIRST, 5'd16, KIND_LOAD, 4'd5,  16'hAAAA,  1'b1, '{1'b0, 4'd5, 16'hAAAA}},
        '{FIT_FIRST, 5'd16, KIND_LOAD, 4'd6,  16'h5555,  1'b1, '{1'b0, 4'd6, 16'h5555}},
        '{FIT_WORST, 5'd16, KIND_REQ,  4'd0,  16'h5555,  1'b0, UNTYPED}
    };

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_wr_en   = 1'b0;
    logic             i_cfg_index   = 1'b0;
    logic [CFG_W-1:0] i_cfg_data    = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [23:0]      s_axis_tdata  = '0;   // load_index[3:0], amount[19:4]
    logic             s_axis_tuser  = 1'b0; // kind
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [23:0]      m_axis_tdata;         // block_number[3:0], remaining[19:4]
    logic             m_axis_tuser;         // granted

    logic [AMOUNT_W-1:0] free_size [TABLE_DEPTH];
    logic [MODE_W-1:0]   cur_mode  = FIT_FIRST;
    logic [COUNT_W-1:0]  cur_count = BLOCK_COUNT_RST;
    t_alloc_result       pending_results [$];

    bit no_gaps     = 1'b0;
    bit hold_wanted = 1'b0;
    bit hold_done   = 1'b0;
    int stall_left  = 0;
    int errors      = 0;
    int items_sent  = 0;
    int loads_sent  = 0;
    int results_seen = 0;
    int grants_seen = 0;
    int setting_changes = 0;

    fit_policy_block_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_alloc_result predict_alloc(input logic kind,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic [AMOUNT_W-1:0] amt);
        t_alloc_result r = '0;
        int n;
        int pick = 0;
        bit found = 1'b0;
        n = (cur_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_count);
        if (kind == KIND_LOAD) begin
            free_size[idx] = amt;
            r.block = idx;
            r.remaining = amt;
            return r;
        end
        for (int j = 0; j < n; j++) begin
            case (cur_mode)
                FIT_BEST: begin
                    if (free_size[j] >= amt && (!found || free_size[j] < free_size[pick])) begin
                        pick = j;
                        found = 1'b1;
                    end
                end
                FIT_WORST: begin
                    if (!found || free_size[j] > free_size[pick]) begin
                        pick = j;
                        found = 1'b1;
                    end
                end
                default: begin
                    if (!found && free_size[j] >= amt) begin
                        pick = j;
                        found = 1'b1;
                    end
                end
            endcase
        end
        if (cur_mode == FIT_WORST && found && free_size[pick] < amt)
            found = 1'b0;
        if (found) begin
            free_size[pick] = free_size[pick] - amt;
            r.granted = 1'b1;
            r.block = pick[IDX_W-1:0];
            r.remaining = free_size[pick];
        end
        return r;
    endfunction

    task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx,
                             input logic [AMOUNT_W-1:0] amt, input logic typed,
                             input t_alloc_result typed_res);
        t_alloc_result r;
        int gap = 0;
        if (!no_gaps)
            while ($urandom_range(99) < 27)
                gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {4'b0, amt, idx};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        r = predict_alloc(kind, idx, amt);
        pending_results.push_back(typed ? typed_res : r);
        items_sent++;
        if (kind == KIND_LOAD)
            loads_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [MODE_W-1:0] mode,
                                  input logic [COUNT_W-1:0] count);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_FIT_MODE;
        i_cfg_data  <= CFG_W'(mode);
        @(posedge i_clk);
        i_cfg_index <= CFG_BLOCK_COUNT;
        i_cfg_data  <= count;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_mode  = mode;
        cur_count = count;
        setting_changes++;
    endtask

    // check results and pace the result side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (m_axis_tuser)
                    grants_seen++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result: granted %0d block %0d remaining %0d",
                           m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4]);
                    errors++;
                end else begin
                    t_alloc_result want;
                    want = pending_results.pop_front();
                    if (m_axis_tuser !== want.granted) begin
                        $error("granted: expected %0d, got %0d", want.granted, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[3:0] !== want.block) begin
                        $error("block_number: expected %0d, got %0d",
                               want.block, m_axis_tdata[3:0]);
                        errors++;
                    end
                    if (m_axis_tdata[19:4] !== want.remaining) begin
                        $error("remaining: expected %0d, got %0d",
                               want.remaining, m_axis_tdata[19:4]);
                        errors++;
                    end
                end
            end
            if (hold_wanted && !hold_done) begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= no_gaps || ($urandom_range(99) >= 27);
            end
        end
    end

    initial begin
        logic                kind;
        logic [IDX_W-1:0]    idx;
        logic [AMOUNT_W-1:0] amt;
        logic [MODE_W-1:0]   mode;
        logic [COUNT_W-1:0]  count;

        foreach (free_size[k])
            free_size[k] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (PLAN[k]) begin
            if (PLAN[k].mode != cur_mode || PLAN[k].count != cur_count) begin
                drain_results();
                write_settings(PLAN[k].mode, PLAN[k].count);
            end
            send_item(PLAN[k].kind, PLAN[k].idx, PLAN[k].amount, PLAN[k].typed, PLAN[k].res);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            mode = MODE_W'(ph % 4);
            case (ph)
                0:       count = 5'd16;
                1:       count = 5'd0;
                2:       count = 5'd31;
                3:       count = 5'd1;
                5:       count = COUNT_W'($urandom_range(31, 17));
                default: count = COUNT_W'($urandom_range(16, 1));
            endcase
            write_settings(mode, count);
            no_gaps = (ph == 4);
            if (ph == 6)
                hold_wanted = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                kind = ($urandom_range(99) < 35) ? KIND_LOAD : KIND_REQ;
                idx  = IDX_W'($urandom_range(15));
                case ($urandom_range(7))
                    0:       amt = AMOUNT_W'($urandom);
                    1:       amt = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                    default: amt = (kind == KIND_LOAD) ? AMOUNT_W'($urandom_range(2000))
                                                       : AMOUNT_W'($urandom_range(600, 1));
                endcase
                send_item(kind, idx, amt, 1'b0, UNTYPED);
            end
            no_gaps = 1'b0;
        end

        drain_results();
        repeat (30) @(posedge i_clk);

        $display("run covered %0d items (%0d loads) over %0d policy/count settings,",
                 items_sent, loads_sent, setting_changes);
        $display("with %0d results checked, %0d of them granted requests", results_seen,
                 grants_seen);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- fit_policy_block_allocator.f -----
hw/rtl/fpba_pkg.sv
hw/rtl/fpba_front.sv
hw/rtl/fpba_back.sv
hw/rtl/fit_policy_block_allocator.sv
bench/tb_fit_policy_block_allocator.sv
